// File: src/scsa_pkg.sv
// scsa_pkg: shared types and codes for the sprite slot stack allocator
// used by the top level, the output register and the checker; depends on nothing
`default_nettype none

package scsa_pkg;

  localparam int SLOT_W   = 7;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int HIGH_W   = SLOT_W + 1;

  localparam logic [CMD_W-1:0] CMD_ALLOC       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE_ALL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REFRESH     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_LINK    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_QUERY       = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [SLOT_W-1:0]        first_index;
    logic [SLOT_W-1:0]        available;
    logic signed [HIGH_W-1:0] highest_index;
    logic [SLOT_W-1:0]        last_index;
  } result_t;

endpackage

`default_nettype wire

// File: src/scsa_ram.sv
// scsa_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module scsa_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 80
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/scsa_vram.sv
// scsa_vram: ram with one valid bit per entry, cleared at once by reset or clear
// depends on scsa_ram
`default_nettype none

module scsa_vram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 80
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     clear,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata,
  output logic                          rvalid
);

  logic [DEPTH-1:0] valid;

  scsa_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else begin
      rvalid <= valid[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/scsa_out_reg.sv
// scsa_out_reg: result register between the sequencer and the result channel
// depends on scsa_pkg
`default_nettype none

module scsa_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire scsa_pkg::result_t din,
  input  wire logic              res_stall,
  output logic                   res_valid,
  output logic                   free,
  output scsa_pkg::result_t      dout
);

  assign free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

`default_nettype wire

// File: src/sprite_chain_stack_allocator.sv
// sprite_chain_stack_allocator: top level, command sequencer over the free stack and link rams
// depends on scsa_pkg, scsa_vram, scsa_out_reg
//
// usage: one command word in on cmd/slot_index/slot_count/link_value (cmd_valid, cmd_stall),
// one result word out on status/first_index/available/highest_index/last_index
// (res_valid, res_stall). a word moves at a clock edge with valid high and stall low.
// one command is in work at a time; cmd_stall is high from acceptance until the
// result has been loaded into the output register.
// allocate pops slots from the free stack and links each to the one before it, release
// follows the chain and pushes each slot back, refresh scans the allocated entries for
// the highest index; everything else and every rejected command goes straight to loading
// the result. the free stack and link rams take one access per cycle with a registered read.
// a new command is taken the cycle after the result is loaded, while the result may
// still wait in the output register.
// if the receiver holds res_stall, the result stays and the next finished result waits
// in the sequencer until the register frees.
// reset: synchronous, active high; the stack reads as slots SLOT_COUNT-1 down to 0 with
// slot 0 on top, all links zero, highest index -1, last index 0. valid bits in flops
// stand in for a clearing pass, so the block is ready right after reset.
`default_nettype none

module sprite_chain_stack_allocator #(
  parameter int SLOT_COUNT = 80
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cmd_valid,
  output logic                                      cmd_stall,
  input  wire logic [scsa_pkg::CMD_W-1:0]           cmd,
  input  wire logic [scsa_pkg::SLOT_W-1:0]          slot_index,
  input  wire logic [scsa_pkg::SLOT_W-1:0]          slot_count,
  input  wire logic [scsa_pkg::SLOT_W-1:0]          link_value,
  output logic                                      res_valid,
  input  wire logic                                 res_stall,
  output logic [scsa_pkg::STATUS_W-1:0]             status,
  output logic [scsa_pkg::SLOT_W-1:0]               first_index,
  output logic [scsa_pkg::SLOT_W-1:0]               available,
  output logic signed [scsa_pkg::HIGH_W-1:0]        highest_index,
  output logic [scsa_pkg::SLOT_W-1:0]               last_index
);

  localparam int SW    = scsa_pkg::SLOT_W;
  localparam int HW    = scsa_pkg::HIGH_W;
  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOT_COUNT);
  localparam logic [SW:0]      SLOT_LIM = SLOT_COUNT[SW:0];
  localparam logic [SW+1:0]    REL_LIM  = SLOT_COUNT[SW+1:0];
  localparam logic signed [HW-1:0] NONE = -1;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_ALLOC     = 3'd1;
  localparam logic [2:0] S_ALLOC_END = 3'd2;
  localparam logic [2:0] S_REL       = 3'd3;
  localparam logic [2:0] S_REF       = 3'd4;
  localparam logic [2:0] S_FIN       = 3'd5;

  logic [2:0]                         state, state_next;
  logic [CNT_W-1:0]                   free_cnt, free_cnt_next;
  logic signed [HW-1:0]               highest, highest_next;
  logic [SW-1:0]                      last_slot, last_slot_next;
  logic [SW-1:0]                      left, left_next;
  logic                               first_pend, first_pend_next;
  logic [SW-1:0]                      cur, cur_next;
  logic signed [HW-1:0]               top, top_next;
  logic [CNT_W-1:0]                   ptr, ptr_next;
  logic [scsa_pkg::STATUS_W-1:0]      status_q, status_q_next;
  logic [SW-1:0]                      first_q, first_q_next;
  logic [IDX_W-1:0]                   stk_raddr_q;

  logic                               stk_we, stk_clear;
  logic [IDX_W-1:0]                   stk_waddr, stk_raddr;
  logic [SW-1:0]                      stk_wdata, stk_rdata;
  logic                               stk_rvld;
  logic                               lnk_we;
  logic [IDX_W-1:0]                   lnk_waddr, lnk_raddr;
  logic [SW-1:0]                      lnk_wdata, lnk_rdata;
  logic                               lnk_rvld;

  logic [SW-1:0]                      stk_word, lnk_word, lnk_next;
  logic signed [HW-1:0]               stk_word_s, best;
  logic [CNT_W-1:0]                   fc_dec;
  logic [SW+1:0]                      rel_sum;
  logic                               idx_ok, cnt_fits;
  logic                               load, out_free;
  scsa_pkg::result_t                  res_in, res_out;

  scsa_vram #(
    .WIDTH(SW),
    .DEPTH(SLOT_COUNT)
  ) u_stack (
    .clk   (clk),
    .rst   (rst),
    .clear (stk_clear),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata),
    .rvalid(stk_rvld)
  );

  scsa_vram #(
    .WIDTH(SW),
    .DEPTH(SLOT_COUNT)
  ) u_link (
    .clk   (clk),
    .rst   (rst),
    .clear (1'b0),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (lnk_raddr),
    .rdata (lnk_rdata),
    .rvalid(lnk_rvld)
  );

  // unwritten stack entries read as their reset slot, unwritten links as zero
  assign stk_word   = stk_rvld ? stk_rdata : SW'(LAST_IDX - stk_raddr_q);
  assign stk_word_s = {1'b0, stk_word};
  assign best       = (stk_word_s > top) ? stk_word_s : top;
  assign lnk_word   = lnk_rvld ? lnk_rdata : '0;
  assign lnk_next   = ({1'b0, lnk_word} < SLOT_LIM) ? lnk_word : '0;

  assign fc_dec   = free_cnt - CNT_W'(1);
  assign rel_sum  = (SW+2)'(free_cnt) + (SW+2)'(slot_count);
  assign idx_ok   = {1'b0, slot_index} < SLOT_LIM;
  assign cnt_fits = {1'b0, slot_count} <= (SW+1)'(free_cnt);

  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    free_cnt_next   = free_cnt;
    highest_next    = highest;
    last_slot_next  = last_slot;
    left_next       = left;
    first_pend_next = first_pend;
    cur_next        = cur;
    top_next        = top;
    ptr_next        = ptr;
    status_q_next   = status_q;
    first_q_next    = first_q;
    stk_we          = 1'b0;
    stk_clear       = 1'b0;
    stk_waddr       = free_cnt[IDX_W-1:0];
    stk_wdata       = lnk_next;
    stk_raddr       = ptr[IDX_W-1:0];
    lnk_we          = 1'b0;
    lnk_waddr       = cur[IDX_W-1:0];
    lnk_wdata       = '0;
    lnk_raddr       = lnk_next[IDX_W-1:0];
    load            = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          status_q_next = scsa_pkg::ST_OK;
          first_q_next  = '0;
          state_next    = S_FIN;
          unique case (cmd)
            scsa_pkg::CMD_ALLOC: begin
              if (slot_count == '0) begin
                status_q_next = scsa_pkg::ST_ZERO;
              end else if (!cnt_fits) begin
                status_q_next = scsa_pkg::ST_SHORT;
              end else begin
                stk_raddr       = fc_dec[IDX_W-1:0];
                free_cnt_next   = fc_dec;
                left_next       = slot_count - SW'(1);
                first_pend_next = 1'b1;
                state_next      = S_ALLOC;
              end
            end
            scsa_pkg::CMD_RELEASE: begin
              if (slot_count == '0) begin
                status_q_next = scsa_pkg::ST_ZERO;
              end else if (!idx_ok) begin
                status_q_next = scsa_pkg::ST_OK;
              end else if (rel_sum > REL_LIM) begin
                status_q_next = scsa_pkg::ST_OVERFLOW;
              end else begin
                stk_we        = 1'b1;
                stk_waddr     = free_cnt[IDX_W-1:0];
                stk_wdata     = slot_index;
                free_cnt_next = free_cnt + CNT_W'(1);
                left_next     = slot_count - SW'(1);
                lnk_raddr     = slot_index[IDX_W-1:0];
                if (slot_count != SW'(1)) begin
                  state_next = S_REL;
                end
              end
            end
            scsa_pkg::CMD_RELEASE_ALL: begin
              stk_clear     = 1'b1;
              free_cnt_next = FULL_CNT;
              highest_next  = NONE;
            end
            scsa_pkg::CMD_REFRESH: begin
              if (free_cnt == FULL_CNT) begin
                highest_next = NONE;
              end else begin
                stk_raddr  = free_cnt[IDX_W-1:0];
                ptr_next   = free_cnt + CNT_W'(1);
                top_next   = NONE;
                state_next = S_REF;
              end
            end
            scsa_pkg::CMD_SET_LINK: begin
              if (idx_ok) begin
                lnk_we    = 1'b1;
                lnk_waddr = slot_index[IDX_W-1:0];
                lnk_wdata = link_value;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ALLOC: begin
        // one popped slot arrives each cycle
        if (first_pend) begin
          first_q_next    = stk_word;
          top_next        = stk_word_s;
          first_pend_next = 1'b0;
        end else begin
          lnk_we    = 1'b1;
          lnk_waddr = cur[IDX_W-1:0];
          lnk_wdata = stk_word;
          top_next  = best;
        end
        cur_next = stk_word;
        if (left != '0) begin
          stk_raddr     = fc_dec[IDX_W-1:0];
          free_cnt_next = fc_dec;
          left_next     = left - SW'(1);
        end else begin
          state_next = S_ALLOC_END;
        end
      end
      S_ALLOC_END: begin
        lnk_we         = 1'b1;
        lnk_waddr      = cur[IDX_W-1:0];
        lnk_wdata      = '0;
        last_slot_next = cur;
        if (top > highest) begin
          highest_next = top;
        end
        state_next = S_FIN;
      end
      S_REL: begin
        // follow the chain and push each slot
        stk_we        = 1'b1;
        stk_waddr     = free_cnt[IDX_W-1:0];
        stk_wdata     = lnk_next;
        free_cnt_next = free_cnt + CNT_W'(1);
        left_next     = left - SW'(1);
        lnk_raddr     = lnk_next[IDX_W-1:0];
        if (left == SW'(1)) begin
          state_next = S_FIN;
        end
      end
      S_REF: begin
        top_next = best;
        if (ptr != FULL_CNT) begin
          stk_raddr = ptr[IDX_W-1:0];
          ptr_next  = ptr + CNT_W'(1);
        end else begin
          highest_next = best;
          state_next   = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_cnt  <= FULL_CNT;
      highest   <= NONE;
      last_slot <= '0;
    end else begin
      state     <= state_next;
      free_cnt  <= free_cnt_next;
      highest   <= highest_next;
      last_slot <= last_slot_next;
    end
  end

  always_ff @(posedge clk) begin
    left        <= left_next;
    first_pend  <= first_pend_next;
    cur         <= cur_next;
    top         <= top_next;
    ptr         <= ptr_next;
    status_q    <= status_q_next;
    first_q     <= first_q_next;
    stk_raddr_q <= stk_raddr;
  end

  always_comb begin
    res_in.status        = status_q;
    res_in.first_index   = first_q;
    res_in.available     = SW'(free_cnt);
    res_in.highest_index = highest;
    res_in.last_index    = last_slot;
  end

  scsa_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .din      (res_in),
    .res_stall(res_stall),
    .res_valid(res_valid),
    .free     (out_free),
    .dout     (res_out)
  );

  assign status        = res_out.status;
  assign first_index   = res_out.first_index;
  assign available     = res_out.available;
  assign highest_index = res_out.highest_index;
  assign last_index    = res_out.last_index;

endmodule

`default_nettype wire

// File: src/scsa_check.sv
// scsa_check: port-level assertions for the sprite slot stack allocator, bound to the top
// depends on scsa_pkg and sprite_chain_stack_allocator
`default_nettype none

module scsa_check #(
  parameter int SLOT_COUNT = 80
) (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 cmd_valid,
  input wire logic                                 cmd_stall,
  input wire logic [scsa_pkg::CMD_W-1:0]           cmd,
  input wire logic [scsa_pkg::SLOT_W-1:0]          slot_index,
  input wire logic [scsa_pkg::SLOT_W-1:0]          slot_count,
  input wire logic [scsa_pkg::SLOT_W-1:0]          link_value,
  input wire logic                                 res_valid,
  input wire logic                                 res_stall,
  input wire logic [scsa_pkg::STATUS_W-1:0]        status,
  input wire logic [scsa_pkg::SLOT_W-1:0]          first_index,
  input wire logic [scsa_pkg::SLOT_W-1:0]          available,
  input wire logic [scsa_pkg::HIGH_W-1:0]          highest_index,
  input wire logic [scsa_pkg::SLOT_W-1:0]          last_index
);

  localparam logic [scsa_pkg::SLOT_W:0] SLOT_LIM = SLOT_COUNT[scsa_pkg::SLOT_W:0];

  logic unused_inputs;
  assign unused_inputs = ^{cmd, slot_index, slot_count, link_value};

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(status) && $stable(first_index)
      && $stable(available) && $stable(highest_index) && $stable(last_index))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command taken while another is in work");

  a_first_only_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (status == scsa_pkg::ST_OK) || (first_index == '0))
    else $error("first index reported on a failed command");

  a_avail_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> {1'b0, available} <= SLOT_LIM)
    else $error("available count above pool size");

  a_highest_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (highest_index == '1)
      || (!highest_index[scsa_pkg::HIGH_W-1] && (highest_index < SLOT_LIM)))
    else $error("highest index out of range");

endmodule

bind sprite_chain_stack_allocator scsa_check #(
  .SLOT_COUNT(SLOT_COUNT)
) u_scsa_check (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd_valid),
  .cmd_stall    (cmd_stall),
  .cmd          (cmd),
  .slot_index   (slot_index),
  .slot_count   (slot_count),
  .link_value   (link_value),
  .res_valid    (res_valid),
  .res_stall    (res_stall),
  .status       (status),
  .first_index  (first_index),
  .available    (available),
  .highest_index(highest_index),
  .last_index   (last_index)
);

`default_nettype wire
